### src/sequential_mean_change_detector_core_macros.svh
// Assertion macros used by the change detector datapath.
`ifndef SEQUENTIAL_MEAN_CHANGE_DETECTOR_CORE_MACROS_SVH
`define SEQUENTIAL_MEAN_CHANGE_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define SMCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smcd same-cycle check failed");

// Next-cycle implication
`define SMCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smcd next-cycle check failed");

`endif

### src/smcd_pkg.sv
// Package: widths, codes, state and command types of the change detector.
`timescale 1ns / 1ps
package smcd_pkg;

	localparam int MAX_LEN = 1024;
	localparam int CNT_W   = $clog2(MAX_LEN + 1);
	localparam int POS_W   = 11;
	localparam int SMP_W   = 16;
	localparam int SUM_W   = 27;
	localparam int LL_W    = 10;
	localparam logic [LL_W-1:0] LL_RESET = 10'd64;
	localparam int STAT_W  = 48;
	localparam int FRAC_SH = 32;

	// split-point arithmetic
	localparam int PROD_W  = SUM_W + CNT_W + 1;
	localparam int DIFF_W  = PROD_W + 1;
	localparam int A_W     = SUM_W + CNT_W - 1;
	localparam int AL_W    = (A_W + 1) / 2;
	localparam int AH_W    = A_W - AL_W;
	localparam int SUMA_W  = A_W + CNT_W;
	localparam int SUMA2_W = 2 * A_W + CNT_W;
	localparam int CX_W    = A_W + CNT_W;

	// root and divider units
	localparam int SQ_W    = LL_W / 2 + 17;
	localparam int RT_W    = (SUMA2_W + FRAC_SH + 1) / 2;
	localparam int RAD_W   = 2 * RT_W;
	localparam int NUM_W   = SUMA_W + FRAC_SH;
	localparam int DEN_W   = 2 * LL_W + SQ_W + 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_INIT, ST_RD, ST_MUL, ST_ABS, ST_SQ1, ST_SQ2, ST_ACC,
		ST_SQM, ST_SQM_W, ST_PROD1, ST_PROD2, ST_SQP, ST_SQP_W,
		ST_DIVR, ST_DIVR_W, ST_DIVS, ST_DIVS_W, ST_DIVT, ST_DIVT_W,
		ST_DIVE, ST_DIVE_W, ST_DIVQ, ST_DIVQ_W, ST_LOAD
	} state_t;

	typedef enum logic [2:0] {DIV_R, DIV_S, DIV_T, DIV_E, DIV_Q} div_sel_t;
	typedef enum logic {SQRT_M, SQRT_P} sqrt_sel_t;

	typedef struct packed {
		logic      accept;
		logic      walk_init;
		logic      mul;
		logic      absv;
		logic      sq1;
		logic      sq2;
		logic      acc;
		logic      sqrt_start;
		sqrt_sel_t sqrt_sel;
		logic      prod1;
		logic      prod2;
		logic      div_start;
		div_sel_t  div_sel;
		logic      load_out;
	} cmd_t;

	typedef struct packed {
		logic monitor;
		logic walk_end;
		logic sqrt_done;
		logic div_done;
		logic arg_e_none;
		logic out_full;
	} status_t;

endpackage

### src/smcd_ifs.sv
// Channel interfaces: sample input, result output and configuration write.
`timescale 1ns / 1ps
interface smcd_sample_if import smcd_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;
	logic                    first;
	modport source (output valid, sample, first, input ready);
	modport sink (input valid, sample, first, output ready);
endinterface

interface smcd_result_if import smcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  position;
	logic [STAT_W-1:0] stat_r;
	logic [STAT_W-1:0] stat_s;
	logic [STAT_W-1:0] stat_t;
	logic [STAT_W-1:0] stat_e;
	logic [STAT_W-1:0] stat_q;
	logic [POS_W-1:0]  argmax_r;
	logic [POS_W-1:0]  argmax_e;
	logic              saturated;
	modport source (output valid, position, stat_r, stat_s, stat_t, stat_e, stat_q,
		argmax_r, argmax_e, saturated, input ready);
	modport sink (input valid, position, stat_r, stat_s, stat_t, stat_e, stat_q,
		argmax_r, argmax_e, saturated, output ready);
endinterface

interface smcd_cfg_if import smcd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [LL_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/smcd_div.sv
// Bit-serial restoring divider with saturation of the quotient to 48 bits.
`timescale 1ns / 1ps
module smcd_div import smcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              busy,
	output logic              done,
	output logic [STAT_W-1:0] quot,
	output logic              sat
);
	localparam int DCNT_W = $clog2(NUM_W + 1);

	logic [DCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W:0]    rem_diff;
	logic              fits;
	logic              over;

	// one quotient bit per cycle
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign fits     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DCNT_W'(1));
			if (start) begin
				cnt_q <= DCNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// clip to the output range
	assign over = |quo_q[NUM_W-1:STAT_W];
	assign quot = over ? '1 : quo_q[STAT_W-1:0];
	assign sat  = over;
	assign busy = (cnt_q != '0);
	assign done = done_q;

endmodule

### src/smcd_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module smcd_sqrt import smcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RAD_W-1:0] rad,
	output logic             done,
	output logic [RT_W-1:0]  root
);
	localparam int REM_W  = RT_W + 3;
	localparam int SCNT_W = $clog2(RT_W + 1);

	logic [SCNT_W-1:0] cnt_q;
	logic              done_q;
	logic [RAD_W-1:0]  rad_q;
	logic [RT_W-1:0]   root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == SCNT_W'(1));
			if (start) begin
				cnt_q <= SCNT_W'(RT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			root_q <= '0;
			rem_q  <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### src/smcd_datapath.sv
// Datapath: prefix-sum RAM, split-point accumulators, root and divider units, result register.
`timescale 1ns / 1ps
`include "sequential_mean_change_detector_core_macros.svh"
module smcd_datapath import smcd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output status_t                 status,
	input  logic signed [SMP_W-1:0] sample,
	input  logic                    first,
	input  logic                    cfg_valid,
	input  logic [LL_W-1:0]         cfg_data,
	output logic                    cfg_ready,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [POS_W-1:0]        position,
	output logic [STAT_W-1:0]       stat_r,
	output logic [STAT_W-1:0]       stat_s,
	output logic [STAT_W-1:0]       stat_t,
	output logic [STAT_W-1:0]       stat_e,
	output logic [STAT_W-1:0]       stat_q,
	output logic [POS_W-1:0]        argmax_r,
	output logic [POS_W-1:0]        argmax_e,
	output logic                    saturated
);
	logic signed [SUM_W-1:0] mem [0:MAX_LEN];

	logic [LL_W-1:0]          cfg_q;
	logic [LL_W-1:0]          m_eff;
	logic [LL_W-1:0]          m_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     mon_q;
	logic [CNT_W-1:0]         base_cnt;
	logic signed [SUM_W-1:0]  base_sum;
	logic [CNT_W-1:0]         k_nx;
	logic signed [SUM_W-1:0]  sk_nx;
	logic                     full;

	logic [CNT_W-1:0]         j_q;
	logic signed [SUM_W-1:0]  rd_q;
	logic signed [PROD_W-1:0] pa_q;
	logic signed [PROD_W-1:0] pb_q;
	logic signed [DIFF_W-1:0] diff;
	logic [A_W-1:0]           a_q;
	logic [2*AL_W-1:0]        pp0_q;
	logic [AH_W+AL_W-1:0]     pp1_q;
	logic [2*AH_W-1:0]        pp2_q;
	logic [CX_W-1:0]          cx1_q;
	logic [CX_W-1:0]          cx2_q;
	logic [A_W-1:0]           best_r_q;
	logic [CNT_W-1:0]         arg_r_q;
	logic [SUMA_W-1:0]        sum_a_q;
	logic [SUMA2_W-1:0]       sum_a2_q;
	logic [A_W-1:0]           best_ea_q;
	logic [CNT_W-1:0]         best_ej_q;
	logic [CNT_W-1:0]         arg_e_q;
	logic [A_W-1:0]           a_m_q;

	logic [SQ_W-1:0]          sq_q;
	logic [RT_W-1:0]          rt_q;
	logic [LL_W+SQ_W-1:0]     msq_q;
	logic [2*LL_W-1:0]        mm_q;
	logic [DEN_W-1:0]         mmsq_q;
	logic [CNT_W+SQ_W-1:0]    esq_q;

	logic [STAT_W-1:0]        st_r_q, st_s_q, st_t_q, st_e_q, st_q_q;
	logic                     sat_q;
	sqrt_sel_t                sqrt_sel_q;
	div_sel_t                 div_sel_q;

	logic [RAD_W-1:0]         sqrt_rad;
	logic                     sqrt_done;
	logic [RT_W-1:0]          sqrt_root;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic                     div_busy;
	logic                     div_done;
	logic [STAT_W-1:0]        div_quot;
	logic                     div_sat;

	logic                     out_valid_q;
	logic                     out_xfer;

	// length register, zero acts as one
	assign cfg_ready = 1'b1;
	assign m_eff     = (cfg_q == '0) ? LL_W'(1) : cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= LL_RESET;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	// sample intake: count, running sum, next prefix entry
	assign base_cnt = first ? '0 : count_q;
	assign base_sum = first ? '0 : sum_q;
	assign full     = (base_cnt == CNT_W'(MAX_LEN));
	assign k_nx     = base_cnt + 1'b1;
	assign sk_nx    = base_sum + SUM_W'(sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			mon_q   <= 1'b0;
		end else if (cmd.accept) begin
			mon_q <= !full && (k_nx > CNT_W'(m_eff));
			if (!full) begin
				count_q <= k_nx;
				sum_q   <= sk_nx;
			end
		end
	end

	// prefix-sum RAM, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.accept && !full) begin
			mem[k_nx] <= sk_nx;
		end
		rd_q <= mem[j_q];
	end

	// split-point walk
	assign diff = DIFF_W'(pa_q) - DIFF_W'(pb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q       <= '0;
			best_ej_q <= CNT_W'(1);
		end else if (cmd.walk_init) begin
			j_q       <= CNT_W'(m_eff);
			best_ej_q <= CNT_W'(1);
		end else if (cmd.acc) begin
			j_q <= j_q + 1'b1;
			if (cx1_q > cx2_q) begin
				best_ej_q <= j_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			m_q       <= m_eff;
			best_r_q  <= '0;
			arg_r_q   <= '0;
			sum_a_q   <= '0;
			sum_a2_q  <= '0;
			best_ea_q <= '0;
			arg_e_q   <= '0;
			a_m_q     <= '0;
		end
		if (cmd.mul) begin
			pa_q <= rd_q * $signed({1'b0, count_q});
			pb_q <= sum_q * $signed({1'b0, j_q});
		end
		if (cmd.absv) begin
			a_q <= diff[DIFF_W-1] ? A_W'(-diff) : A_W'(diff);
		end
		if (cmd.sq1) begin
			pp0_q   <= a_q[AL_W-1:0] * a_q[AL_W-1:0];
			pp1_q   <= a_q[A_W-1:AL_W] * a_q[AL_W-1:0];
			cx1_q   <= a_q * best_ej_q;
			cx2_q   <= best_ea_q * j_q;
			sum_a_q <= sum_a_q + SUMA_W'(a_q);
			if (a_q > best_r_q) begin
				best_r_q <= a_q;
				arg_r_q  <= j_q;
			end
			if (j_q == CNT_W'(m_q)) begin
				a_m_q <= a_q;
			end
		end
		if (cmd.sq2) begin
			pp2_q <= a_q[A_W-1:AL_W] * a_q[A_W-1:AL_W];
		end
		if (cmd.acc) begin
			sum_a2_q <= sum_a2_q + SUMA2_W'(pp0_q) + (SUMA2_W'(pp1_q) << (AL_W + 1))
				+ (SUMA2_W'(pp2_q) << (2 * AL_W));
			if (cx1_q > cx2_q) begin
				best_ea_q <= a_q;
				arg_e_q   <= j_q;
			end
		end
	end

	// root unit: sqrt(m) scale, then root of the squared-term sum
	assign sqrt_rad = (cmd.sqrt_sel == SQRT_M) ? RAD_W'({m_q, 32'b0})
		: RAD_W'({sum_a2_q, 32'b0});

	smcd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (sqrt_rad),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// divisor products
	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sqrt_sel_q <= cmd.sqrt_sel;
		end
		if (sqrt_done) begin
			if (sqrt_sel_q == SQRT_M) begin
				sq_q <= sqrt_root[SQ_W-1:0];
			end else begin
				rt_q <= sqrt_root;
			end
		end
		if (cmd.prod1) begin
			msq_q <= m_q * sq_q;
			mm_q  <= m_q * m_q;
		end
		if (cmd.prod2) begin
			mmsq_q <= DEN_W'(mm_q * sq_q);
			esq_q  <= best_ej_q * sq_q;
		end
	end

	// divider operand select
	always_comb begin
		case (cmd.div_sel)
			DIV_R: begin
				div_num = NUM_W'({best_r_q, 32'b0});
				div_den = DEN_W'(msq_q);
			end
			DIV_S: begin
				div_num = NUM_W'({sum_a_q, 32'b0});
				div_den = mmsq_q;
			end
			DIV_T: begin
				div_num = NUM_W'(rt_q);
				div_den = DEN_W'(mm_q);
			end
			DIV_E: begin
				div_num = NUM_W'({best_ea_q, 32'b0});
				div_den = DEN_W'(esq_q);
			end
			DIV_Q: begin
				div_num = NUM_W'({a_m_q, 32'b0});
				div_den = DEN_W'(msq_q);
			end
			default: begin
				div_num = '0;
				div_den = '1;
			end
		endcase
	end

	smcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot),
		.sat    (div_sat)
	);

	// statistic capture
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			st_e_q <= '0;
			sat_q  <= 1'b0;
		end
		if (cmd.div_start) begin
			div_sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			sat_q <= sat_q | div_sat;
			case (div_sel_q)
				DIV_R:   st_r_q <= div_quot;
				DIV_S:   st_s_q <= div_quot;
				DIV_T:   st_t_q <= div_quot;
				DIV_E:   st_e_q <= div_quot;
				DIV_Q:   st_q_q <= div_quot;
				default: st_q_q <= div_quot;
			endcase
		end
	end

	// result register
	assign out_xfer = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			position  <= POS_W'(count_q);
			stat_r    <= st_r_q;
			stat_s    <= st_s_q;
			stat_t    <= st_t_q;
			stat_e    <= st_e_q;
			stat_q    <= st_q_q;
			argmax_r  <= POS_W'(arg_r_q);
			argmax_e  <= POS_W'(arg_e_q);
			saturated <= sat_q;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	always_comb begin
		status.monitor    = mon_q;
		status.walk_end   = (CNT_W'(j_q + 1'b1) == count_q);
		status.sqrt_done  = sqrt_done;
		status.div_done   = div_done;
		status.arg_e_none = (arg_e_q == '0);
		status.out_full   = out_valid_q;
	end

	`SMCD_ASSERT_NOW(a_walk_in_range, cmd.acc, j_q < count_q)
	`SMCD_ASSERT_NOW(a_load_into_empty, cmd.load_out, !out_valid_q)
	`SMCD_ASSERT_NOW(a_div_start_idle, cmd.div_start, !div_busy)
	`SMCD_ASSERT_NEXT(a_walk_start_split, cmd.walk_init, j_q < count_q && j_q != '0)

endmodule

### src/smcd_ctrl.sv
// Controller: sequences intake, split-point walk, root and divide steps, result load.
`timescale 1ns / 1ps
module smcd_ctrl import smcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_CHECK;
			ST_CHECK:  state_nx = status.monitor ? ST_INIT : ST_IDLE;
			ST_INIT:   state_nx = ST_RD;
			ST_RD:     state_nx = ST_MUL;
			ST_MUL:    state_nx = ST_ABS;
			ST_ABS:    state_nx = ST_SQ1;
			ST_SQ1:    state_nx = ST_SQ2;
			ST_SQ2:    state_nx = ST_ACC;
			ST_ACC:    state_nx = status.walk_end ? ST_SQM : ST_RD;
			ST_SQM:    state_nx = ST_SQM_W;
			ST_SQM_W:  if (status.sqrt_done) state_nx = ST_PROD1;
			ST_PROD1:  state_nx = ST_PROD2;
			ST_PROD2:  state_nx = ST_SQP;
			ST_SQP:    state_nx = ST_SQP_W;
			ST_SQP_W:  if (status.sqrt_done) state_nx = ST_DIVR;
			ST_DIVR:   state_nx = ST_DIVR_W;
			ST_DIVR_W: if (status.div_done) state_nx = ST_DIVS;
			ST_DIVS:   state_nx = ST_DIVS_W;
			ST_DIVS_W: if (status.div_done) state_nx = ST_DIVT;
			ST_DIVT:   state_nx = ST_DIVT_W;
			ST_DIVT_W: begin
				if (status.div_done) begin
					state_nx = status.arg_e_none ? ST_DIVQ : ST_DIVE;
				end
			end
			ST_DIVE:   state_nx = ST_DIVE_W;
			ST_DIVE_W: if (status.div_done) state_nx = ST_DIVQ;
			ST_DIVQ:   state_nx = ST_DIVQ_W;
			ST_DIVQ_W: if (status.div_done) state_nx = ST_LOAD;
			ST_LOAD:   if (!status.out_full) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_INIT:  cmd.walk_init = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_ABS:   cmd.absv = 1'b1;
			ST_SQ1:   cmd.sq1 = 1'b1;
			ST_SQ2:   cmd.sq2 = 1'b1;
			ST_ACC:   cmd.acc = 1'b1;
			ST_SQM: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_sel   = SQRT_M;
			end
			ST_PROD1: cmd.prod1 = 1'b1;
			ST_PROD2: cmd.prod2 = 1'b1;
			ST_SQP: begin
				cmd.sqrt_start = 1'b1;
				cmd.sqrt_sel   = SQRT_P;
			end
			ST_DIVR: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_R;
			end
			ST_DIVS: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_S;
			end
			ST_DIVT: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_T;
			end
			ST_DIVE: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_E;
			end
			ST_DIVQ: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_Q;
			end
			ST_LOAD:  cmd.load_out = !status.out_full;
			default:  cmd = '0;
		endcase
	end

endmodule

### src/sequential_mean_change_detector_core.sv
// Learning or ignored sample: after the transfer the controller passes ST_CHECK before the next sample is taken.
// Monitoring sample k with learning length m: each split point from m to k-1 is walked through
//   ST_RD, ST_MUL, ST_ABS, ST_SQ1, ST_SQ2 and ST_ACC on the prefix-sum RAM read port, then the
//   bit-serial root unit runs twice and the divider up to 5 times (4 when no E term is positive).
// One sample in work at a time; the result register holds a result while the next is taken.
// arst_n clears the count and control and sets the length register to 64.
`timescale 1ns / 1ps
module sequential_mean_change_detector_core import smcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	smcd_sample_if.sink   samples,
	smcd_result_if.source results,
	smcd_cfg_if.sink      cfg
);
	cmd_t    cmd;
	status_t status;

	smcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	smcd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample    (samples.sample),
		.first     (samples.first),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cfg_ready (cfg.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.position  (results.position),
		.stat_r    (results.stat_r),
		.stat_s    (results.stat_s),
		.stat_t    (results.stat_t),
		.stat_e    (results.stat_e),
		.stat_q    (results.stat_q),
		.argmax_r  (results.argmax_r),
		.argmax_e  (results.argmax_e),
		.saturated (results.saturated)
	);

endmodule

### dv/tb_top.sv
// Self-checking testbench for the sequential mean change detector core.
`timescale 1ns / 1ps
module tb_top;
	import smcd_pkg::*;

	localparam logic [47:0] STAT_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int QUIET_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 100;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [STAT_W-1:0] stat_r;
		logic [STAT_W-1:0] stat_s;
		logic [STAT_W-1:0] stat_t;
		logic [STAT_W-1:0] stat_e;
		logic [STAT_W-1:0] stat_q;
		logic [POS_W-1:0]  argmax_r;
		logic [POS_W-1:0]  argmax_e;
		logic              saturated;
	} detect_t;

	typedef struct packed {
		logic              wr_len;
		logic [LL_W-1:0]   len;
		logic [SMP_W-1:0]  sample;
		logic              first;
		logic              typed;
		detect_t           want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	smcd_sample_if smp ();
	smcd_result_if res ();
	smcd_cfg_if    cfg_ch ();

	sequential_mean_change_detector_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp),
		.results(res),
		.cfg    (cfg_ch)
	);

	// detector shadow state
	logic [LL_W-1:0]   len_shadow;
	longint            psum [0:MAX_LEN];
	int                seq_count;
	detect_t           pending_detect [$];

	// typed expectation riding along with the driven sample
	logic              item_typed;
	detect_t           item_want;

	int  mismatches;
	int  detections_seen;
	int  samples_sent;
	int  quiet_cycles;
	bit  calm;
	int  ready_hold;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	// integer square root of a 128-bit value
	function automatic logic [63:0] isqrt128(input logic [127:0] n);
		logic [63:0]  root;
		logic [63:0]  c;
		logic [127:0] c2;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			c = root | (64'd1 << b);
			c2 = {64'd0, c} * {64'd0, c};
			if (c2 <= n)
				root = c;
		end
		return root;
	endfunction

	// saturating quotient of the statistic scaling
	function automatic logic [STAT_W-1:0] quot_sat(input logic [127:0] n, input logic [63:0] d,
		inout logic clipped);
		logic [127:0] q;
		if (d == 0) begin
			clipped = 1'b1;
			return STAT_MAX;
		end
		q = n / {64'd0, d};
		if (q > {80'd0, STAT_MAX}) begin
			clipped = 1'b1;
			return STAT_MAX;
		end
		return q[STAT_W-1:0];
	endfunction

	// one sample into the shadow detector; returns 1 when a detection is due
	function automatic bit detect_step(input logic [SMP_W-1:0] smp_in, input logic first_in,
		output detect_t d_out);
		longint       x, sk, diff;
		logic [63:0]  k, m, a, best_r, best_ea, best_ej, arg_r, arg_e, sum_a, a_m, sq;
		logic [64:0]  sum_next;
		logic [127:0] sum_a2, lhs, rhs, num;
		logic [63:0]  rt;
		logic         clipped;
		x = longint'($signed(smp_in));
		d_out = '0;
		if (first_in)
			seq_count = 0;
		if (seq_count >= MAX_LEN)
			return 0;
		k = 64'(seq_count + 1);
		psum[k] = psum[k - 1] + x;
		seq_count = int'(k);
		m = (len_shadow == 0) ? 64'd1 : {54'd0, len_shadow};
		if (k <= m)
			return 0;
		sk = psum[k];
		best_r = 0; best_ea = 0; best_ej = 1; arg_r = 0; arg_e = 0;
		sum_a = 0; a_m = 0; sum_a2 = 0; clipped = 1'b0;
		for (longint j = m; j < k; j++) begin
			diff = psum[j] * longint'(k) - sk * j;
			a = (diff < 0) ? -diff : diff;
			if (j == m)
				a_m = a;
			if (a > best_r) begin
				best_r = a;
				arg_r = j;
			end
			sum_next = {1'b0, sum_a} + {1'b0, a};
			sum_a = sum_next[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_next[63:0];
			sum_a2 = sum_a2 + {64'd0, a} * {64'd0, a};
			lhs = {64'd0, a} * {64'd0, best_ej};
			rhs = {64'd0, best_ea} * {64'd0, 64'(j)};
			if (lhs > rhs) begin
				best_ea = a;
				best_ej = j;
				arg_e = j;
			end
		end
		sq = isqrt128({64'd0, m << 32});
		d_out.position = k[POS_W-1:0];
		d_out.stat_r = quot_sat({32'd0, best_r, 32'd0}, m * sq, clipped);
		d_out.stat_s = quot_sat({32'd0, sum_a, 32'd0}, m * m * sq, clipped);
		if (sum_a2[127:96] == 0) begin
			rt = isqrt128(sum_a2 << 32);
			num = {64'd0, rt};
		end else begin
			rt = isqrt128(sum_a2);
			num = {64'd0, rt} << 16;
		end
		d_out.stat_t = quot_sat(num, m * m, clipped);
		d_out.stat_e = (arg_e == 0) ? '0 :
			quot_sat({32'd0, best_ea, 32'd0}, best_ej * sq, clipped);
		d_out.stat_q = quot_sat({32'd0, a_m, 32'd0}, m * sq, clipped);
		d_out.argmax_r = arg_r[POS_W-1:0];
		d_out.argmax_e = arg_e[POS_W-1:0];
		d_out.saturated = clipped;
		return 1;
	endfunction

	// predict on every sample transfer, track the length register on every write
	always @(posedge clk) begin
		detect_t d;
		if (smp.valid && smp.ready) begin
			samples_sent++;
			if (detect_step(smp.sample, smp.first, d))
				pending_detect.push_back(item_typed ? item_want : d);
		end
		if (cfg_ch.valid && cfg_ch.ready)
			len_shadow <= cfg_ch.data;
	end

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		detect_t got;
		detect_t want;
		if (res.valid && res.ready) begin
			got = '{res.position, res.stat_r, res.stat_s, res.stat_t, res.stat_e, res.stat_q,
				res.argmax_r, res.argmax_e, res.saturated};
			detections_seen++;
			if (pending_detect.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at position %0d", got.position);
			end else begin
				want = pending_detect.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch pos exp %0d got %0d", want.position, got.position);
						$display("  r exp %0d got %0d | s exp %0d got %0d", want.stat_r,
							got.stat_r, want.stat_s, got.stat_s);
						$display("  t exp %0d got %0d | e exp %0d got %0d", want.stat_t,
							got.stat_t, want.stat_e, got.stat_e);
						$display("  q exp %0d got %0d | arg r %0d/%0d e %0d/%0d sat %0d/%0d",
							want.stat_q, got.stat_q, want.argmax_r, got.argmax_r,
							want.argmax_e, got.argmax_e, want.saturated, got.saturated);
					end
				end
			end
		end
	end

	// result-side backpressure: mostly ready, short stalls, now and then a long one
	always @(posedge clk) begin
		int r;
		if (!arst_n || calm) begin
			res.ready <= 1'b1;
			ready_hold <= 0;
		end else if (ready_hold > 0) begin
			res.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 70)
				res.ready <= 1'b1;
			else if (r < 95) begin
				res.ready <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				res.ready <= 1'b0;
				ready_hold <= $urandom_range(20, 60);
			end
		end
	end

	// watchdog on cycles with no transfer anywhere
	always @(posedge clk) begin
		if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("sequential_mean_change_detector_core regression: fail");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one sample transfer; valid stays high when the next sample follows at once
	task automatic push_sample(input logic [SMP_W-1:0] s, input logic f, input logic typed,
		input detect_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.sample <= s;
		smp.first <= f;
		item_typed <= typed;
		item_want <= want;
		do @(posedge clk); while (!smp.ready);
	endtask

	// stop sending and wait until every expected result has come
	task automatic drain();
		smp.valid <= 1'b0;
		@(posedge clk);
		while (pending_detect.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_len(input logic [LL_W-1:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [SMP_W-1:0] rand_sample(input int mode);
		case (mode)
			0: return SMP_W'($urandom);
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return SMP_W'($urandom_range(0, 64) - 32);
		endcase
	endfunction

	localparam detect_t FULL_SWING = '{11'd2, 48'd4294901760, 48'd4294901760, 48'd4294901760,
		48'd4294901760, 48'd4294901760, 11'd1, 11'd1, 1'b0};
	localparam detect_t FLAT_TWO = '{11'd2, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 11'd0, 11'd0, 1'b0};

	// directed part: zero length, extremes, length change mid-sequence
	localparam plan_row_t PLAN [0:23] = '{
		'{1'b1, 10'd0,    16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h7FFF, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    16'h8000, 1'b0, 1'b1, FULL_SWING},
		'{1'b0, 10'd0,    16'h0000, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    16'h0000, 1'b0, 1'b1, FLAT_TWO},
		'{1'b0, 10'd0,    16'hFFFF, 1'b0, 1'b0, '0},
		'{1'b1, 10'd2,    16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h0064, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    16'hFF9C, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h1388, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h8000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h7FFF, 1'b0, 1'b0, '0},
		'{1'b1, 10'd1023, 16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h0001, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    16'hFFFF, 1'b0, 1'b0, '0},
		'{1'b1, 10'd1,    16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h0007, 1'b0, 1'b0, '0},
		'{1'b1, 10'd3,    16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h8000, 1'b1, 1'b0, '0},
		'{1'b0, 10'd0,    16'h8000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h8000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h7FFF, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'h0000, 1'b0, 1'b0, '0},
		'{1'b0, 10'd0,    16'hFFFB, 1'b0, 1'b0, '0}
	};

	initial begin
		detect_t none;
		detect_t flat65;
		int      len, mode, lo, hi, shift_at, rnd_items, m_pick;
		none = '0;
		flat65 = '0;
		flat65.position = 11'd65;
		arst_n <= 1'b0;
		smp.valid <= 1'b0;
		smp.sample <= '0;
		smp.first <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		item_typed <= 1'b0;
		item_want <= '0;
		len_shadow <= LL_RESET;
		seq_count = 0;
		psum[0] = 0;
		mismatches = 0;
		detections_seen = 0;
		samples_sent = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// length register after reset: a flat run of 65 gives one all-zero result
		for (int i = 1; i <= 65; i++)
			push_sample(16'd1000, i == 1, i == 65, flat65);

		foreach (PLAN[i]) begin
			if (PLAN[i].wr_len)
				write_len(PLAN[i].len);
			else
				push_sample(PLAN[i].sample, PLAN[i].first, PLAN[i].typed, PLAN[i].want);
		end

		// clipping: learning run of opposite extremes, then length dropped to 1 mid-sequence
		write_len(10'd200);
		for (int i = 1; i <= 100; i++)
			push_sample(i <= 50 ? 16'h7FFF : 16'h8000, i == 1, 1'b0, none);
		write_len(10'd1);
		push_sample(16'h8000, 1'b0, 1'b0, none);

		// random sequences with a mean shift, some noise and broken sequences
		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			m_pick = $urandom_range(0, 9);
			if (m_pick < 7)
				write_len(LL_W'($urandom_range(0, 6)));
			else if (m_pick < 9)
				write_len(LL_W'($urandom_range(7, 40)));
			calm = ($urandom_range(0, 5) == 0);
			len = (cfg_ch.data == '0 ? 1 : int'(cfg_ch.data)) + int'($urandom_range(1, 20));
			mode = $urandom_range(0, 3);
			lo = $urandom_range(0, 65535);
			hi = $urandom_range(0, 65535);
			shift_at = $urandom_range(1, len);
			for (int i = 1; i <= len; i++) begin
				case (mode)
					0, 1, 2: push_sample(rand_sample(mode), i == 1, 1'b0, none);
					default: push_sample(SMP_W'((i < shift_at ? lo : hi) +
						$urandom_range(0, 15)), i == 1, 1'b0, none);
				endcase
				rnd_items++;
				if ($urandom_range(0, 99) < 3) begin
					push_sample(rand_sample(0), 1'b1, 1'b0, none);
					rnd_items++;
				end
			end
			if ($urandom_range(0, 4) == 0) begin
				write_len(LL_W'($urandom_range(0, 3)));
				push_sample(rand_sample(0), 1'b0, 1'b0, none);
				rnd_items++;
			end
		end
		calm = 1'b0;

		drain();
		repeat (500) @(posedge clk);
		$display("covered %0d samples and %0d checked results: zero, shortest and longest",
			samples_sent, detections_seen);
		$display("learning lengths, extreme swings, clipping and length changes");
		if (mismatches == 0 && pending_detect.size() == 0)
			$display("sequential_mean_change_detector_core regression: pass");
		else
			$display("sequential_mean_change_detector_core regression: fail");
		$finish;
	end

endmodule
